// File: rtl/core/acrms_pkg.sv
// acrms_pkg: widths, reset values, register indexes and shared types for the
// AC RMS voltage monitor. No dependencies; used by every file in rtl/core.
package acrms_pkg;

   // ADC scaling; ADC_FULL_SCALE must be a power of two
   localparam int ADC_FULL_SCALE     = 1024;
   localparam int ADC_SHIFT          = $clog2(ADC_FULL_SCALE);
   localparam int MAX_WINDOW_SAMPLES = 65535;

   // field widths
   localparam int SAMPLE_W = 10;
   localparam int TGT_W    = 8;
   localparam int TIME_W   = 16;
   localparam int CAL_W    = 16;
   localparam int RMS_W    = 14;
   localparam int WS_W     = 16;
   localparam int WS_MAX   = (1 << WS_W) - 1;
   localparam int RMS_MAX  = (1 << RMS_W) - 1;

   // datapath widths
   localparam int CNT_W       = $clog2(MAX_WINDOW_SAMPLES + 1);
   localparam int FRAC_W      = 16;
   localparam int OFS_W       = SAMPLE_W + FRAC_W;
   localparam int FILT_SHIFT  = 10;
   localparam int F_W         = OFS_W - FILT_SHIFT + 1;
   localparam int SQ_W        = 2 * F_W - 1;
   localparam int SUM_W       = 52;
   localparam int ROOT_W      = SUM_W / 2;
   localparam int REM_W       = ROOT_W + 2;
   localparam int STEP_W      = $clog2(SUM_W);
   localparam int DIV_STEPS   = SUM_W;
   localparam int SQRT_STEPS  = ROOT_W;
   localparam int SCALE_SHIFT = 14 + ADC_SHIFT;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CROSSING_TARGET = 3'd0,
      CSR_TIMEOUT_MS      = 3'd1,
      CSR_CALIBRATION     = 3'd2,
      CSR_FAULT_HIGH      = 3'd3,
      CSR_FAULT_LOW       = 3'd4
   } csr_idx_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   localparam logic [TGT_W-1:0]  RST_CROSSING_TARGET = 8'd10;
   localparam logic [TIME_W-1:0] RST_TIMEOUT_MS      = 16'd200;
   localparam logic [CAL_W-1:0]  RST_CALIBRATION     = 16'd64819;
   localparam logic [RMS_W-1:0]  RST_FAULT_HIGH      = 14'd2540;
   localparam logic [RMS_W-1:0]  RST_FAULT_LOW       = 14'd1900;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } ds_status_type;

endpackage

// File: rtl/core/acrms_div_sqrt.sv
// acrms_div_sqrt: mean of squares and its integer square root, one bit of the
// quotient or one root digit per cycle through a single shared subtractor.
// Depends on acrms_pkg.
module acrms_div_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [acrms_pkg::SUM_W-1:0]   sum,
   input  logic [acrms_pkg::CNT_W-1:0]   count,
   output acrms_pkg::ds_status_type      status
);
   import acrms_pkg::*;

   typedef enum logic [1:0] {U_IDLE, U_DIV, U_SQRT} ustate_type;

   localparam int SUB_W = REM_W + 2;

   ustate_type        state_ff, state_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  work_ff, work_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic [SUB_W-1:0]  sub_a, sub_b;
   logic [SUB_W:0]    sub_diff;
   logic              fits;

   always_comb begin
      sub_a = '0;
      sub_b = '0;
      unique case (state_ff)
         U_DIV: begin
            sub_a = SUB_W'({rem_ff[CNT_W-1:0], work_ff[SUM_W-1]});
            sub_b = SUB_W'(den_ff);
         end
         U_SQRT: begin
            sub_a = {rem_ff, work_ff[SUM_W-1 -: 2]};
            sub_b = SUB_W'({root_ff, 2'b01});
         end
         default: ;
      endcase
      sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
      fits     = ~sub_diff[SUB_W];
   end

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      den_in   = den_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (start) begin
               work_in  = sum;
               den_in   = count;
               rem_in   = '0;
               step_in  = STEP_W'(DIV_STEPS - 1);
               state_in = U_DIV;
            end
         end
         U_DIV: begin
            rem_in  = fits ? REM_W'(sub_diff[CNT_W-1:0]) : REM_W'(sub_a[CNT_W-1:0]);
            work_in = {work_ff[SUM_W-2:0], fits};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = STEP_W'(SQRT_STEPS - 1);
               state_in = U_SQRT;
            end
         end
         U_SQRT: begin
            rem_in  = fits ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], fits};
            work_in = {work_ff[SUM_W-3:0], 2'b00};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               done_in  = 1'b1;
               state_in = U_IDLE;
            end
         end
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      den_ff  <= den_in;
   end

   assign status.done = done_ff;
   assign status.root = root_ff;

endmodule

// File: rtl/core/ac_rms_voltage_monitor.sv
// ac_rms_voltage_monitor: top level. Sync, DC offset tracking, sum of squares
// and window control; RMS scaling and fault check. Depends on acrms_pkg and
// acrms_div_sqrt.
//
// Usage: the req channel carries beats of either an ADC sample (opcode 0,
// with sample and zero_cross_flag) or a millisecond tick (opcode 1). During
// sync every sample becomes the crossing reference; a flagged sample or a
// sync timeout opens a measurement window. A window closes when the crossing
// count reaches crossing_target, on timeout, or at MAX_WINDOW_SAMPLES, and
// then one rsp beat carries rms_tenths, fault, empty_window, window_samples.
// Flow: ticks and sync samples are handled in the idle state; a window sample
// goes through offset update, square and accumulate. Closing a window runs
// 52 divide steps and 26 root steps in the shared divide/root unit, then the
// scaling states; an empty window skips the unit and goes straight to output.
// The rsp beat sits in an output register; if the receiver stalls, the block
// keeps taking req beats and only waits when the next result is ready.
// The csr port writes one register per cycle; use it only while idle.
// Reset (synchronous, active high) restores register defaults and enters sync.
module ac_rms_voltage_monitor (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic [acrms_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                               req_zero_cross_flag,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [acrms_pkg::RMS_W-1:0]        rsp_rms_tenths,
   output logic                               rsp_fault,
   output logic                               rsp_empty_window,
   output logic [acrms_pkg::WS_W-1:0]         rsp_window_samples,
   input  logic                               csr_wr_en,
   input  logic [acrms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [acrms_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import acrms_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DC, S_MUL, S_ACC, S_ROOT, S_SCL1, S_SCL2, S_SCL3, S_OUT
   } state_type;

   localparam int PROD_W = CAL_W + ROOT_W;
   localparam int P50_W  = PROD_W + 6;
   localparam logic [P50_W:0] ROUND_HALF = (P50_W + 1)'(1) << (SCALE_SHIFT - 1);

   // control and state
   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                ds_start_ff, ds_start_in;
   logic                measuring_ff, measuring_in;
   logic [TIME_W-1:0]   elapsed_ff, elapsed_in;
   logic [SAMPLE_W-1:0] ref_ff, ref_in;
   logic [OFS_W-1:0]    dc_ff, dc_in;
   logic                prev_ff, prev_in;
   logic [TGT_W-1:0]    crossing_ff, crossing_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [TGT_W-1:0]    target_ff, target_in;
   logic [TIME_W-1:0]   timeout_ff, timeout_in;
   logic [CAL_W-1:0]    cal_ff, cal_in;
   logic [RMS_W-1:0]    high_ff, high_in;
   logic [RMS_W-1:0]    low_ff, low_in;

   // payload
   logic [SAMPLE_W-1:0] x_ff, x_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [P50_W-1:0]    p50_ff, p50_in;
   logic [RMS_W-1:0]    rms_ff, rms_in;
   logic                empty_ff, empty_in;
   logic [RMS_W-1:0]    out_rms_ff, out_rms_in;
   logic                out_fault_ff, out_fault_in;
   logic                out_empty_ff, out_empty_in;
   logic [WS_W-1:0]     out_ws_ff, out_ws_in;

   // datapath
   logic signed [OFS_W:0]     ofs_diff;
   logic signed [OFS_W:0]     leak;
   logic signed [OFS_W:0]     filt_full;
   logic signed [F_W-1:0]     filt;
   logic signed [2*F_W-1:0]   sq_full;
   logic [SUM_W:0]            sum_ext;
   logic [SUM_W-1:0]          sum_sat;
   logic [TIME_W:0]           elapsed_next;
   logic                      above;
   logic [P50_W:0]            rounded;
   logic [P50_W:0]            scaled;
   logic                      fault_now;
   logic                      start_window;
   logic                      finish;
   ds_status_type             ds_status;

   acrms_div_sqrt u_div_sqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (ds_start_ff),
      .sum    (sum_ff),
      .count  (count_ff),
      .status (ds_status)
   );

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      ofs_diff     = $signed({1'b0, x_ff, {FRAC_W{1'b0}}}) - $signed({1'b0, dc_ff});
      leak         = ofs_diff >>> ADC_SHIFT;
      filt_full    = ofs_diff >>> FILT_SHIFT;
      filt         = filt_full[F_W-1:0];
      sq_full      = filt * filt;
      sum_ext      = {1'b0, sum_ff} + (SUM_W + 1)'(sq_ff);
      sum_sat      = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      elapsed_next = {1'b0, elapsed_ff} + 1'b1;
      above        = (x_ff > ref_ff);
      rounded      = {1'b0, p50_ff} + ROUND_HALF;
      scaled       = rounded >> SCALE_SHIFT;
      fault_now    = (rms_ff > high_ff) || ((low_ff != '0) && (rms_ff < low_ff));
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      ds_start_in  = 1'b0;
      measuring_in = measuring_ff;
      elapsed_in   = elapsed_ff;
      ref_in       = ref_ff;
      dc_in        = dc_ff;
      prev_in      = prev_ff;
      crossing_in  = crossing_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      target_in    = target_ff;
      timeout_in   = timeout_ff;
      cal_in       = cal_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      x_in         = x_ff;
      sq_in        = sq_ff;
      prod_in      = prod_ff;
      p50_in       = p50_ff;
      rms_in       = rms_ff;
      empty_in     = empty_ff;
      out_rms_in   = out_rms_ff;
      out_fault_in = out_fault_ff;
      out_empty_in = out_empty_ff;
      out_ws_in    = out_ws_ff;
      start_window = 1'b0;
      finish       = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CROSSING_TARGET: target_in  = csr_wdata[TGT_W-1:0];
            CSR_TIMEOUT_MS:      timeout_in = csr_wdata[TIME_W-1:0];
            CSR_CALIBRATION:     cal_in     = csr_wdata[CAL_W-1:0];
            CSR_FAULT_HIGH:      high_in    = csr_wdata[RMS_W-1:0];
            CSR_FAULT_LOW:       low_in     = csr_wdata[RMS_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in = req_sample;
               if (!measuring_ff) begin
                  if (req_opcode == OP_TICK) begin
                     if (elapsed_next > {1'b0, timeout_ff}) begin
                        start_window = 1'b1;
                     end else begin
                        elapsed_in = elapsed_next[TIME_W-1:0];
                     end
                  end else begin
                     ref_in = req_sample;
                     if (req_zero_cross_flag) begin
                        start_window = 1'b1;
                     end
                  end
               end else if (req_opcode == OP_TICK) begin
                  if (elapsed_next >= {1'b0, timeout_ff}) begin
                     finish = 1'b1;
                  end else begin
                     elapsed_in = elapsed_next[TIME_W-1:0];
                  end
               end else begin
                  count_in = count_ff + 1'b1;
                  state_in = S_DC;
               end
            end
         end
         S_DC: begin
            dc_in = dc_ff + leak[OFS_W-1:0];
            if ((count_ff != CNT_W'(1)) && (above != prev_ff) && (crossing_ff != '1)) begin
               crossing_in = crossing_ff + 1'b1;
            end
            prev_in  = above;
            state_in = S_MUL;
         end
         S_MUL: begin
            sq_in    = sq_full[SQ_W-1:0];
            state_in = S_ACC;
         end
         S_ACC: begin
            sum_in = sum_sat;
            if ((crossing_ff >= target_ff) || (32'(count_ff) >= MAX_WINDOW_SAMPLES)) begin
               finish = 1'b1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ROOT: begin
            if (ds_status.done) begin
               state_in = S_SCL1;
            end
         end
         S_SCL1: begin
            prod_in  = cal_ff * ds_status.root;
            state_in = S_SCL2;
         end
         S_SCL2: begin
            // x50 as shift-add
            p50_in   = (P50_W'(prod_ff) << 5) + (P50_W'(prod_ff) << 4) + (P50_W'(prod_ff) << 1);
            state_in = S_SCL3;
         end
         S_SCL3: begin
            rms_in   = (scaled > (P50_W + 1)'(RMS_MAX)) ? RMS_W'(RMS_MAX) : scaled[RMS_W-1:0];
            empty_in = 1'b0;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_rms_in   = rms_ff;
               out_fault_in = fault_now;
               out_empty_in = empty_ff;
               out_ws_in    = (32'(count_ff) > WS_MAX) ? WS_W'(WS_MAX) : WS_W'(count_ff);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (start_window) begin
         measuring_in = 1'b1;
         elapsed_in   = '0;
         crossing_in  = '0;
         count_in     = '0;
         sum_in       = '0;
      end

      if (finish) begin
         measuring_in = 1'b0;
         elapsed_in   = '0;
         if (count_ff == '0) begin
            rms_in   = '0;
            empty_in = 1'b1;
            state_in = S_OUT;
         end else begin
            ds_start_in = 1'b1;
            state_in    = S_ROOT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ds_start_ff  <= 1'b0;
         measuring_ff <= 1'b0;
         elapsed_ff   <= '0;
         ref_ff       <= '0;
         dc_ff        <= '0;
         prev_ff      <= 1'b0;
         crossing_ff  <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         target_ff    <= RST_CROSSING_TARGET;
         timeout_ff   <= RST_TIMEOUT_MS;
         cal_ff       <= RST_CALIBRATION;
         high_ff      <= RST_FAULT_HIGH;
         low_ff       <= RST_FAULT_LOW;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ds_start_ff  <= ds_start_in;
         measuring_ff <= measuring_in;
         elapsed_ff   <= elapsed_in;
         ref_ff       <= ref_in;
         dc_ff        <= dc_in;
         prev_ff      <= prev_in;
         crossing_ff  <= crossing_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         target_ff    <= target_in;
         timeout_ff   <= timeout_in;
         cal_ff       <= cal_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      sq_ff        <= sq_in;
      prod_ff      <= prod_in;
      p50_ff       <= p50_in;
      rms_ff       <= rms_in;
      empty_ff     <= empty_in;
      out_rms_ff   <= out_rms_in;
      out_fault_ff <= out_fault_in;
      out_empty_ff <= out_empty_in;
      out_ws_ff    <= out_ws_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rms_tenths     = out_rms_ff;
   assign rsp_fault          = out_fault_ff;
   assign rsp_empty_window   = out_empty_ff;
   assign rsp_window_samples = out_ws_ff;

endmodule

// File: rtl/core/acrms_checker.sv
// acrms_checker: port-level assertions for ac_rms_voltage_monitor, bound to
// the top level below. Depends on acrms_pkg.
module acrms_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [acrms_pkg::RMS_W-1:0]        rsp_rms_tenths,
   input logic                               rsp_fault,
   input logic                               rsp_empty_window,
   input logic [acrms_pkg::WS_W-1:0]         rsp_window_samples
);

   // stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rms_tenths) &&
         $stable(rsp_fault) && $stable(rsp_empty_window) && $stable(rsp_window_samples))
      else $error("rsp beat changed while stalled");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_window |-> (rsp_rms_tenths == '0) && (rsp_window_samples == '0))
      else $error("empty window with nonzero result");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_empty_window |-> (rsp_window_samples != '0))
      else $error("non-empty window with zero samples");

   // a result is only produced after the window closed while req was held off
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a window close");

endmodule

bind ac_rms_voltage_monitor acrms_checker u_acrms_checker (.*);
